@@ sv/rmq_pkg.sv @@
// rmq_pkg: widths, output limits and lane select codes of the matrix to quaternion block
// no dependencies; used by the top level and by its port checker

package rmq_pkg;

  localparam int ELEM_W = 16;  // rotation elements and quaternion words
  localparam int MOVE_W = 32;  // translation words
  localparam int QUO_BITS = 15;  // quotient bits below the sign of one output word

  localparam logic signed [ELEM_W-1:0] QMAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] QMIN = 16'sh8000;

  // which quaternion component comes from the square root
  localparam logic [1:0] SEL_W = 2'd0;
  localparam logic [1:0] SEL_X = 2'd1;
  localparam logic [1:0] SEL_Y = 2'd2;
  localparam logic [1:0] SEL_Z = 2'd3;

endpackage

@@ sv/rotation_matrix_to_quaternion.sv @@
// rotation_matrix_to_quaternion: pipelined 3x3 rotation to quaternion conversion
// uses rmq_pkg; the port checker in rmq_checker.sv binds to it
//
// usage notes
// - input channel: valid_i / stall_o carry one word: nine rotation elements with
//   FRAC_BITS fraction bits and a Q16.16 translation; a word is taken at a clock
//   edge with valid_i high and stall_o low
// - output channel: valid_o / stall_i carry the quaternion, the unchanged
//   translation and the degenerate flag
// - throughput: one word per cycle while the receiver does not stall
// - stages: stage a, stage b, the square root with one result bit per stage, the
//   divider setup, the three divisions with one quotient bit per stage and the
//   output register
// - all stages move together; when the output word is held by stall_i, stall_o
//   rises in the same cycle and nothing in flight is lost or repeated
// - reset clears every valid bit; the block takes a word in the first cycle after reset

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r11_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r12_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r13_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r21_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r22_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r23_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r31_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r32_i,
  input  logic signed [rmq_pkg::ELEM_W-1:0]   r33_i,
  input  logic signed [rmq_pkg::MOVE_W-1:0]   move_x_i,
  input  logic signed [rmq_pkg::MOVE_W-1:0]   move_y_i,
  input  logic signed [rmq_pkg::MOVE_W-1:0]   move_z_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [rmq_pkg::ELEM_W-1:0]   quat_w_o,
  output logic signed [rmq_pkg::ELEM_W-1:0]   quat_x_o,
  output logic signed [rmq_pkg::ELEM_W-1:0]   quat_y_o,
  output logic signed [rmq_pkg::ELEM_W-1:0]   quat_z_o,
  output logic signed [rmq_pkg::MOVE_W-1:0]   out_move_x_o,
  output logic signed [rmq_pkg::MOVE_W-1:0]   out_move_y_o,
  output logic signed [rmq_pkg::MOVE_W-1:0]   out_move_z_o,
  output logic                                degenerate_o
);

  localparam int EW   = rmq_pkg::ELEM_W;
  localparam int MW   = rmq_pkg::MOVE_W;
  localparam int QB   = rmq_pkg::QUO_BITS;
  localparam int CW   = EW + 2;                                       // candidate width
  localparam int AW   = ((FRAC_BITS + 1 > CW) ? FRAC_BITS + 1 : CW) + 1; // signed arg
  localparam int UW   = AW - 1;                                       // positive arg
  localparam int NW   = UW + FRAC_BITS - 2;                           // radicand
  localparam int RW   = (NW + 1) / 2;                                 // root
  localparam int DW   = RW + 2;                                       // divisor 4*big
  localparam int MAGW = EW + 1;                                       // off-diagonal term
  localparam int NUMW = MAGW + FRAC_BITS + 1;                         // dividend
  localparam int WW   = ((NUMW > DW + QB) ? NUMW : DW + QB) + 1;      // divider datapath
  localparam int BXW  = (RW > EW) ? RW : EW;
  localparam int SN   = RW + 2 + QB;                                  // stages after A
  localparam int LAT  = SN + 2;

  typedef struct packed {
    logic [1:0]             idx;
    logic                   degen;
    logic signed [MW-1:0]   mx;
    logic signed [MW-1:0]   my;
    logic signed [MW-1:0]   mz;
  } side_t;

  logic en;
  logic [LAT-1:0] vld_q;

  assign en      = !vld_q[LAT-1] || !stall_i;
  assign stall_o = !en;
  assign valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  // stage a: candidates and off-diagonal terms
  logic signed [CW-1:0]   ca_q [4];
  logic signed [MAGW-1:0] pr_q [6];
  side_t                  sa_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ca_q[0] <= CW'(r11_i) + CW'(r22_i) + CW'(r33_i);
      ca_q[1] <= CW'(r11_i) - CW'(r22_i) - CW'(r33_i);
      ca_q[2] <= CW'(r22_i) - CW'(r11_i) - CW'(r33_i);
      ca_q[3] <= CW'(r33_i) - CW'(r11_i) - CW'(r22_i);
      pr_q[0] <= MAGW'(r23_i) - MAGW'(r32_i);
      pr_q[1] <= MAGW'(r31_i) - MAGW'(r13_i);
      pr_q[2] <= MAGW'(r12_i) - MAGW'(r21_i);
      pr_q[3] <= MAGW'(r12_i) + MAGW'(r21_i);
      pr_q[4] <= MAGW'(r31_i) + MAGW'(r13_i);
      pr_q[5] <= MAGW'(r23_i) + MAGW'(r32_i);
      sa_q    <= '{idx: rmq_pkg::SEL_W, degen: 1'b0,
                   mx: move_x_i, my: move_y_i, mz: move_z_i};
    end
  end

  // stage b: pick the largest candidate, clamp the root argument, route terms
  logic signed [CW-1:0]   bb;
  logic [1:0]             bi;
  logic signed [AW-1:0]   argb;
  logic                   degb;
  logic [UW-1:0]          argu;
  logic signed [MAGW-1:0] db [4];

  always_comb begin
    bb = ca_q[0];
    bi = rmq_pkg::SEL_W;
    if (ca_q[1] > bb) begin
      bb = ca_q[1];
      bi = rmq_pkg::SEL_X;
    end
    if (ca_q[2] > bb) begin
      bb = ca_q[2];
      bi = rmq_pkg::SEL_Y;
    end
    if (ca_q[3] > bb) begin
      bb = ca_q[3];
      bi = rmq_pkg::SEL_Z;
    end
    argb = AW'(bb) + (AW'(1) << FRAC_BITS);
    degb = (argb <= 0);
    argu = degb ? UW'(1) : argb[UW-1:0];
    unique case (bi)
      rmq_pkg::SEL_W: begin
        db[0] = '0;       db[1] = pr_q[0]; db[2] = pr_q[1]; db[3] = pr_q[2];
      end
      rmq_pkg::SEL_X: begin
        db[0] = pr_q[0];  db[1] = '0;      db[2] = pr_q[3]; db[3] = pr_q[4];
      end
      rmq_pkg::SEL_Y: begin
        db[0] = pr_q[1];  db[1] = pr_q[3]; db[2] = '0;      db[3] = pr_q[5];
      end
      default: begin
        db[0] = pr_q[2];  db[1] = pr_q[4]; db[2] = pr_q[5]; db[3] = '0;
      end
    endcase
  end

  // side data for stage b, the root stages, the divider setup and the divider
  side_t                  side_q [SN];
  logic signed [MAGW-1:0] sq_d_q [RW+1][4];
  logic [2*RW-1:0]        sq_n_q [RW+1];
  logic [RW+1:0]          sq_rem_q [RW+1];
  logic [RW-1:0]          sq_root_q [RW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0]       <= '{idx: bi, degen: degb, mx: sa_q.mx, my: sa_q.my, mz: sa_q.mz};
      sq_d_q[0]       <= db;
      sq_n_q[0]       <= (2*RW)'({argu, {(FRAC_BITS-2){1'b0}}});
      sq_rem_q[0]     <= '0;
      sq_root_q[0]    <= '0;
    end
  end

  // integer square root, one result bit per stage
  for (genvar s = 1; s <= RW; s++) begin : g_sqrt
    logic [RW+3:0] r2;
    logic [RW+3:0] trial;
    logic          ge;

    assign r2    = {sq_rem_q[s-1], sq_n_q[s-1][2*RW-1 -: 2]};
    assign trial = {2'b00, sq_root_q[s-1], 2'b01};
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[s]    <= side_q[s-1];
        sq_d_q[s]    <= sq_d_q[s-1];
        sq_n_q[s]    <= sq_n_q[s-1] << 2;
        sq_rem_q[s]  <= ge ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
        sq_root_q[s] <= {sq_root_q[s-1][RW-2:0], ge};
      end
    end
  end

  // divider setup: |d| * 2^F + 2*big over 4*big, with an early overflow check
  logic [WW-1:0] dv_rem_q [QB+1][4];
  logic [QB-1:0] dv_quo_q [QB+1][4];
  logic [3:0]    dv_neg_q [QB+1];
  logic [3:0]    dv_ovf_q [QB+1];
  logic [DW-1:0] dv_den_q [QB+1];
  logic [RW-1:0] dv_big_q [QB+1];

  logic [DW-1:0]   den_p;
  logic [MAGW-1:0] mag_p [4];
  logic [WW-1:0]   num_p [4];
  logic [3:0]      neg_p;
  logic [3:0]      ovf_p;

  always_comb begin
    den_p = {sq_root_q[RW], 2'b00};
    for (int j = 0; j < 4; j++) begin
      neg_p[j] = sq_d_q[RW][j][MAGW-1];
      mag_p[j] = neg_p[j] ? MAGW'(-sq_d_q[RW][j]) : MAGW'(sq_d_q[RW][j]);
      num_p[j] = WW'({mag_p[j], {FRAC_BITS{1'b0}}}) + WW'({sq_root_q[RW], 1'b0});
      ovf_p[j] = (num_p[j] >= WW'({den_p, {QB{1'b0}}}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[RW+1] <= side_q[RW];
      dv_rem_q[0]  <= num_p;
      dv_quo_q[0]  <= '{default: '0};
      dv_neg_q[0]  <= neg_p;
      dv_ovf_q[0]  <= ovf_p;
      dv_den_q[0]  <= den_p;
      dv_big_q[0]  <= sq_root_q[RW];
    end
  end

  // restoring division, one quotient bit per stage, four lanes side by side
  for (genvar t = 1; t <= QB; t++) begin : g_div
    logic [WW-1:0] sh;
    logic [3:0]    ge;

    assign sh = WW'(dv_den_q[t-1]) << (QB - t);

    for (genvar j = 0; j < 4; j++) begin : g_lane
      assign ge[j] = (dv_rem_q[t-1][j] >= sh);

      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_rem_q[t][j] <= ge[j] ? dv_rem_q[t-1][j] - sh : dv_rem_q[t-1][j];
          dv_quo_q[t][j] <= {dv_quo_q[t-1][j][QB-2:0], ge[j]};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[RW+1+t] <= side_q[RW+t];
        dv_neg_q[t]    <= dv_neg_q[t-1];
        dv_ovf_q[t]    <= dv_ovf_q[t-1];
        dv_den_q[t]    <= dv_den_q[t-1];
        dv_big_q[t]    <= dv_big_q[t-1];
      end
    end
  end

  // output word: sign, saturation and placement of the root component
  logic signed [EW-1:0] lane_v [4];
  logic signed [EW-1:0] big_v;
  logic signed [EW-1:0] quat_d [4];
  side_t                so;

  assign so = side_q[SN-1];

  always_comb begin
    big_v = (BXW'(dv_big_q[QB]) > BXW'(rmq_pkg::QMAX)) ? rmq_pkg::QMAX
                                                      : EW'(dv_big_q[QB]);
    for (int j = 0; j < 4; j++) begin
      if (dv_ovf_q[QB][j]) begin
        lane_v[j] = dv_neg_q[QB][j] ? rmq_pkg::QMIN : rmq_pkg::QMAX;
      end else if (dv_neg_q[QB][j]) begin
        lane_v[j] = -EW'({1'b0, dv_quo_q[QB][j]});
      end else begin
        lane_v[j] = EW'({1'b0, dv_quo_q[QB][j]});
      end
      quat_d[j] = (so.idx == 2'(j)) ? big_v : lane_v[j];
    end
  end

  logic signed [EW-1:0] quat_q [4];
  side_t                out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q <= quat_d;
      out_q  <= so;
    end
  end

  assign quat_w_o     = quat_q[0];
  assign quat_x_o     = quat_q[1];
  assign quat_y_o     = quat_q[2];
  assign quat_z_o     = quat_q[3];
  assign out_move_x_o = out_q.mx;
  assign out_move_y_o = out_q.my;
  assign out_move_z_o = out_q.mz;
  assign degenerate_o = out_q.degen;

endmodule

@@ sv/rmq_checker.sv @@
// rmq_checker: port-level checks for rotation_matrix_to_quaternion, bound to the top level
// uses rmq_pkg for port widths

module rmq_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                valid_i,
  input logic                                stall_o,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r11_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r12_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r13_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r21_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r22_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r23_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r31_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r32_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   r33_i,
  input logic signed [rmq_pkg::MOVE_W-1:0]   move_x_i,
  input logic signed [rmq_pkg::MOVE_W-1:0]   move_y_i,
  input logic signed [rmq_pkg::MOVE_W-1:0]   move_z_i,
  input logic                                valid_o,
  input logic                                stall_i,
  input logic signed [rmq_pkg::ELEM_W-1:0]   quat_w_o,
  input logic signed [rmq_pkg::ELEM_W-1:0]   quat_x_o,
  input logic signed [rmq_pkg::ELEM_W-1:0]   quat_y_o,
  input logic signed [rmq_pkg::ELEM_W-1:0]   quat_z_o,
  input logic signed [rmq_pkg::MOVE_W-1:0]   out_move_x_o,
  input logic signed [rmq_pkg::MOVE_W-1:0]   out_move_y_o,
  input logic signed [rmq_pkg::MOVE_W-1:0]   out_move_z_o,
  input logic                                degenerate_o
);

  // the input side backs up only behind a held output word
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("stall_o does not follow a held output word");

  // the root component is always positive, so a word is never all zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (quat_w_o > 0 || quat_x_o > 0 || quat_y_o > 0 || quat_z_o > 0))
    else $error("quaternion without a positive component");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !valid_o)
    else $error("valid_o high during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(quat_w_o) && $stable(quat_x_o)
      && $stable(quat_y_o) && $stable(quat_z_o) && $stable(out_move_x_o)
      && $stable(degenerate_o))
    else $error("stalled output word changed");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
